/* sv/tps_pkg.sv */
// Shared types and constants of the terrain pixel shader.
// Used by every module of the block; depends on nothing.
package tps_pkg;

   // Raster height that the latitude term of the temperature is based on.
   localparam int ROWS = 1024;

   localparam int NUM_STAGES = 7;
   localparam int IN_TDATA_W = 112;
   localparam int IN_TUSER_W = 2;
   localparam int OUT_TDATA_W = 24;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [15:0] SEA_LEVEL_RST = -16'sd500;
   localparam logic [11:0] PRECIP_GAIN_RST = 12'd614;
   localparam logic [11:0] TEMP_GAIN_RST = 12'd512;

   localparam logic [7:0] DESERT_RGB [0:2] = '{8'd238, 8'd211, 8'd117};
   localparam logic [7:0] GREEN_RGB [0:2] = '{8'd49, 8'd146, 8'd1};
   localparam logic [7:0] SEA_RGB [0:2] = '{8'd27, 8'd40, 8'd75};

   // Latitude: floor(dist * 2048 / (10 * ROWS)) as dist * LAT_MUL >> LAT_SHIFT.
   localparam longint unsigned LAT_DIV = 64'(10 * ROWS);
   localparam longint unsigned LAT_RECIP = ((64'd1 << 40) + LAT_DIV - 64'd1) / LAT_DIV;
   localparam int LAT_MUL_W = 36;
   localparam logic [LAT_MUL_W-1:0] LAT_MUL = LAT_MUL_W'(LAT_RECIP);
   localparam int LAT_SHIFT = 29;
   localparam int DIST_W = 13;

   // Elevation term: floor(diff * 216 / 9251) as diff * ELE_MUL >> ELE_SHIFT.
   localparam longint unsigned ELE_RECIP = ((64'd1 << 38) + 64'd9250) / 64'd9251;
   localparam int ELE_MUL_W = 33;
   localparam logic [ELE_MUL_W-1:0] ELE_MUL = ELE_MUL_W'(64'd216 * ELE_RECIP);
   localparam int ELE_SHIFT = 38;

   // Shade: floor(mag * 2048 / 125) as mag * LIGHT_MUL >> LIGHT_SHIFT, mag below 2048.
   localparam longint unsigned LIGHT_RECIP = ((64'd1 << 30) + 64'd124) / 64'd125;
   localparam int LIGHT_MUL_W = 24;
   localparam logic [LIGHT_MUL_W-1:0] LIGHT_MUL = LIGHT_MUL_W'(LIGHT_RECIP);
   localparam int LIGHT_SHIFT = 19;
   localparam logic [16:0] SHADE_ONE = 17'd65536;
   localparam logic [16:0] SHADE_MIN = 17'd32768;
   localparam logic [16:0] SHADE_MAX = 17'd98304;

   // Blend weights: floor(y / 255) as y * WEIGHT_RECIP >> 24 for y below 65280.
   localparam logic [16:0] WEIGHT_RECIP = 17'd65794;
   localparam logic [19:0] WEIGHT_SAT = 20'd65280;
   localparam logic [16:0] WEIGHT_ONE = 17'h10000;

   typedef enum logic [1:0] {
      CSR_SEA_LEVEL = 2'd0,
      CSR_PRECIP_GAIN = 2'd1,
      CSR_TEMP_GAIN = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic signed [15:0] sea_level;
      logic [11:0] precip_gain;
      logic [11:0] temp_gain;
   } cfg_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctrl_type;

   typedef struct packed {
      logic signed [15:0] elevation;
      logic signed [15:0] elevation_above;
      logic first_row;
      logic [9:0] row_index;
      logic [7:0] rain_nw;
      logic [7:0] rain_ne;
      logic [7:0] rain_sw;
      logic [7:0] rain_se;
      logic [15:0] frac_x;
      logic [15:0] frac_y;
      logic interp_on;
   } pixel_in_type;

   typedef struct packed {
      logic sea;
      logic [7:0] temp;
      logic [16:0] shade;
      logic [19:0] rain_gain;
   } front_out_type;

endpackage

/* sv/tps_csr.sv */
// Configuration registers of the terrain pixel shader behind an APB-style port.
// Depends on tps_pkg.
module tps_csr
   import tps_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready,
   output cfg_type cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   csr_reg_type sel;
   logic wr_en;

   assign sel = csr_reg_type'(csr_paddr[3:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (sel)
            CSR_SEA_LEVEL: cfg_in.sea_level = csr_pwdata[15:0];
            CSR_PRECIP_GAIN: cfg_in.precip_gain = csr_pwdata[11:0];
            CSR_TEMP_GAIN: cfg_in.temp_gain = csr_pwdata[11:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         CSR_SEA_LEVEL: csr_prdata = CSR_DATA_W'(cfg_ff.sea_level);
         CSR_PRECIP_GAIN: csr_prdata = CSR_DATA_W'(cfg_ff.precip_gain);
         CSR_TEMP_GAIN: csr_prdata = CSR_DATA_W'(cfg_ff.temp_gain);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sea_level <= SEA_LEVEL_RST;
         cfg_ff.precip_gain <= PRECIP_GAIN_RST;
         cfg_ff.temp_gain <= TEMP_GAIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* sv/tps_front.sv */
// Front stages 1 to 3: rain interpolation, latitude and elevation terms,
// shade factor, temperature and the rain gain product. Depends on tps_pkg.
module tps_front
   import tps_pkg::*;
(
   input  logic clock,
   input  pipe_ctrl_type ctrl,
   input  cfg_type cfg,
   input  pixel_in_type pix,
   output front_out_type result
);

   localparam int LAT_PROD_W = DIST_W + LAT_MUL_W;
   localparam int LAT_Q_W = LAT_PROD_W - LAT_SHIFT;
   localparam int ELE_PROD_W = 16 + ELE_MUL_W;
   localparam int ELE_Q_W = ELE_PROD_W - ELE_SHIFT;
   localparam int LIGHT_PROD_W = 11 + LIGHT_MUL_W;

   function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [15:0] f);
      logic [16:0] inv;
      logic [24:0] sum;
      inv = 17'h10000 - {1'b0, f};
      sum = 25'(a) * 25'(inv) + 25'(b) * 25'(f);
      return sum[23:16];
   endfunction

   // Stage 1 registers.
   logic [7:0] s1_top_ff, s1_top_in, s1_bot_ff, s1_bot_in, s1_nw_ff;
   logic [15:0] s1_fy_ff;
   logic s1_interp_ff, s1_sea_ff, s1_sea_in, s1_neg_ff, s1_neg_in, s1_big_ff, s1_big_in;
   logic [10:0] s1_mag_ff, s1_mag_in;
   logic [15:0] s1_diff_ff, s1_diff_in;
   logic [DIST_W-1:0] s1_dist_ff, s1_dist_in;

   logic signed [16:0] light_s, diff_s;
   logic [16:0] light_mag;
   logic signed [13:0] row_off;

   always_comb begin
      s1_top_in = lerp8(pix.rain_nw, pix.rain_ne, pix.frac_x);
      s1_bot_in = lerp8(pix.rain_sw, pix.rain_se, pix.frac_x);
      light_s = pix.first_row ? 17'sd0
                : ({pix.elevation[15], pix.elevation}
                   - {pix.elevation_above[15], pix.elevation_above});
      s1_neg_in = light_s[16];
      light_mag = s1_neg_in ? 17'(-light_s) : 17'(light_s);
      s1_big_in = |light_mag[16:11];
      s1_mag_in = light_mag[10:0];
      diff_s = {pix.elevation[15], pix.elevation} - {cfg.sea_level[15], cfg.sea_level};
      s1_sea_in = diff_s[16] || (diff_s == 17'sd0);
      s1_diff_in = diff_s[15:0];
      row_off = $signed({3'b000, pix.row_index, 1'b0}) - $signed(14'(ROWS));
      s1_dist_in = row_off[13] ? DIST_W'(-row_off) : DIST_W'(row_off);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         s1_top_ff <= s1_top_in;
         s1_bot_ff <= s1_bot_in;
         s1_nw_ff <= pix.rain_nw;
         s1_fy_ff <= pix.frac_y;
         s1_interp_ff <= pix.interp_on;
         s1_sea_ff <= s1_sea_in;
         s1_neg_ff <= s1_neg_in;
         s1_big_ff <= s1_big_in;
         s1_mag_ff <= s1_mag_in;
         s1_diff_ff <= s1_diff_in;
         s1_dist_ff <= s1_dist_in;
      end
   end

   // Stage 2: final interpolation, the two temperature terms and the shade factor.
   logic [7:0] s2_rain_ff, s2_rain_in;
   logic [8:0] s2_lat_ff, s2_lat_in, s2_ele_ff, s2_ele_in;
   logic [16:0] s2_shade_ff, s2_shade_in;
   logic s2_sea_ff;

   logic [LAT_PROD_W-1:0] lat_prod;
   logic [LAT_Q_W-1:0] lat_q;
   logic [ELE_PROD_W-1:0] ele_prod;
   logic [ELE_Q_W-1:0] ele_q;
   logic [LIGHT_PROD_W-1:0] light_prod;
   logic [15:0] light_q;
   logic [17:0] shade_up;

   always_comb begin
      s2_rain_in = s1_interp_ff ? lerp8(s1_top_ff, s1_bot_ff, s1_fy_ff) : s1_nw_ff;
      lat_prod = LAT_PROD_W'(s1_dist_ff) * LAT_PROD_W'(LAT_MUL);
      lat_q = lat_prod[LAT_PROD_W-1:LAT_SHIFT];
      // Any term above 255 already drives the temperature to zero.
      s2_lat_in = (lat_q > LAT_Q_W'(256)) ? 9'd256 : lat_q[8:0];
      ele_prod = ELE_PROD_W'(s1_diff_ff) * ELE_PROD_W'(ELE_MUL);
      ele_q = ele_prod[ELE_PROD_W-1:ELE_SHIFT];
      s2_ele_in = (ele_q > ELE_Q_W'(256)) ? 9'd256 : ele_q[8:0];
      light_prod = LIGHT_PROD_W'(s1_mag_ff) * LIGHT_PROD_W'(LIGHT_MUL);
      light_q = light_prod[LIGHT_SHIFT+15:LIGHT_SHIFT];
      shade_up = 18'(SHADE_ONE) + 18'(light_q);
      if (s1_big_ff) begin
         s2_shade_in = s1_neg_ff ? SHADE_MIN : SHADE_MAX;
      end else if (s1_neg_ff) begin
         s2_shade_in = (17'(light_q) > SHADE_MIN) ? SHADE_MIN : (SHADE_ONE - 17'(light_q));
      end else begin
         s2_shade_in = (shade_up > 18'(SHADE_MAX)) ? SHADE_MAX : shade_up[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         s2_rain_ff <= s2_rain_in;
         s2_lat_ff <= s2_lat_in;
         s2_ele_ff <= s2_ele_in;
         s2_shade_ff <= s2_shade_in;
         s2_sea_ff <= s1_sea_ff;
      end
   end

   // Stage 3: temperature and the rain gain product.
   front_out_type s3_ff, s3_in;
   logic [9:0] rain3;
   logic [17:0] ceil_prod;
   logic [10:0] temp_sub;

   always_comb begin
      // ceil(3 * rain / 10) taken as floor((3 * rain + 9) / 10).
      rain3 = 10'(s2_rain_ff) * 10'd3 + 10'd9;
      ceil_prod = 18'(rain3) * 18'd205;
      temp_sub = 11'(s2_lat_ff) + 11'(s2_ele_ff) + 11'(ceil_prod[17:11]);
      s3_in.sea = s2_sea_ff;
      s3_in.temp = (temp_sub >= 11'd255) ? 8'd0 : 8'(11'd255 - temp_sub);
      s3_in.shade = s2_shade_ff;
      s3_in.rain_gain = 20'(s2_rain_ff) * 20'(cfg.precip_gain);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         s3_ff <= s3_in;
      end
   end

   assign result = s3_ff;

endmodule

/* sv/tps_color.sv */
// Color stages 4 to 7: blend weights, desert/green blend, snow blend and shading.
// Depends on tps_pkg.
module tps_color
   import tps_pkg::*;
(
   input  logic clock,
   input  pipe_ctrl_type ctrl,
   input  cfg_type cfg,
   input  front_out_type front,
   output logic [7:0] red,
   output logic [7:0] green,
   output logic [7:0] blue
);

   function automatic logic [16:0] weight(input logic [19:0] y);
      logic [32:0] prod;
      prod = 33'(y[15:0]) * 33'(WEIGHT_RECIP);
      if (y >= WEIGHT_SAT) begin
         return WEIGHT_ONE;
      end
      return {1'b0, y[15:0]} + 17'(prod[32:24]);
   endfunction

   function automatic logic [7:0] scale8(input logic [7:0] c, input logic [16:0] w);
      logic [24:0] prod;
      prod = 25'(c) * 25'(w);
      return prod[23:16];
   endfunction

   function automatic logic [7:0] add8(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[8] ? 8'd255 : sum[7:0];
   endfunction

   // Stage 4.
   logic [16:0] s4_pw_ff, s4_pw_in, s4_shade_ff;
   logic [19:0] s4_tgy_ff, s4_tgy_in;
   logic s4_sea_ff;

   always_comb begin
      s4_pw_in = weight(front.rain_gain);
      s4_tgy_in = 20'(front.temp) * 20'(cfg.temp_gain);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         s4_pw_ff <= s4_pw_in;
         s4_tgy_ff <= s4_tgy_in;
         s4_shade_ff <= front.shade;
         s4_sea_ff <= front.sea;
      end
   end

   // Stage 5.
   logic [16:0] s5_tw_ff, s5_tw_in, s5_shade_ff;
   logic [7:0] s5_c_ff [0:2];
   logic [7:0] s5_c_in [0:2];
   logic s5_sea_ff;

   always_comb begin
      s5_tw_in = weight(s4_tgy_ff);
      for (int k = 0; k < 3; k++) begin
         s5_c_in[k] = add8(scale8(DESERT_RGB[k], WEIGHT_ONE - s4_pw_ff),
                           scale8(GREEN_RGB[k], s4_pw_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         s5_tw_ff <= s5_tw_in;
         s5_c_ff <= s5_c_in;
         s5_shade_ff <= s4_shade_ff;
         s5_sea_ff <= s4_sea_ff;
      end
   end

   // Stage 6: snow blend toward white.
   logic [7:0] s6_c_ff [0:2];
   logic [7:0] s6_c_in [0:2];
   logic [16:0] s6_shade_ff;
   logic s6_sea_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s6_c_in[k] = add8(scale8(s5_c_ff[k], s5_tw_ff),
                           scale8(8'd255, WEIGHT_ONE - s5_tw_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[5]) begin
         s6_c_ff <= s6_c_in;
         s6_shade_ff <= s5_shade_ff;
         s6_sea_ff <= s5_sea_ff;
      end
   end

   // Stage 7: shading, or the fixed sea color.
   logic [7:0] s7_c_ff [0:2];
   logic [7:0] s7_c_in [0:2];
   logic [24:0] shade_prod [0:2];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         shade_prod[k] = 25'(s6_c_ff[k]) * 25'(s6_shade_ff);
         if (s6_sea_ff) begin
            s7_c_in[k] = SEA_RGB[k];
         end else begin
            s7_c_in[k] = shade_prod[k][24] ? 8'd255 : shade_prod[k][23:16];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[6]) begin
         s7_c_ff <= s7_c_in;
      end
   end

   assign red = s7_c_ff[0];
   assign green = s7_c_ff[1];
   assign blue = s7_c_ff[2];

endmodule

/* sv/terrain_pixel_shader.sv */
// Terrain pixel shader: turns a stream of map pixels into a stream of RGB colors.
// Requests enter on the req_ stream channel, one pixel each; every request gives
// exactly one response on the rsp_ channel, in order. The csr_ port holds the sea
// level and the two blend gains; write it only while no request is in flight.
// One request can be accepted in every clock cycle while rsp_tready is high.
// The seven stages are set by the multiplier chain: interpolation, the temperature
// terms, the two blend weights, the two blends and the shading each take one
// registered stage.
// Each stage holds a valid bit. When the receiver drops rsp_tready, the full stages
// hold their contents and empty stages in front of them still fill, so req_tready
// falls only once the stages are full back to the input. Nothing is lost or repeated.
// Synchronous reset empties the pipeline and loads the register defaults: sea level
// -500, rain gain 614 and temperature gain 512 (Q4.8).
// Depends on tps_pkg, tps_csr, tps_front and tps_color.
module terrain_pixel_shader
   import tps_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // elevation[15:0], elevation_above[31:16], row_index[41:32], rain_nw[49:42],
   // rain_ne[57:50], rain_sw[65:58], rain_se[73:66], frac_x[89:74], frac_y[105:90],
   // zero fill [111:106]
   input  logic [IN_TDATA_W-1:0] req_tdata,
   // first_row[0], interp_on[1]
   input  logic [IN_TUSER_W-1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // red[7:0], green[15:8], blue[23:16]
   output logic [OUT_TDATA_W-1:0] rsp_tdata,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   cfg_type cfg;
   pipe_ctrl_type ctrl;
   pixel_in_type pix;
   front_out_type front;
   logic [7:0] red, green, blue;

   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   logic [NUM_STAGES:0] stage_rdy;

   assign pix.elevation = req_tdata[15:0];
   assign pix.elevation_above = req_tdata[31:16];
   assign pix.first_row = req_tuser[0];
   assign pix.row_index = req_tdata[41:32];
   assign pix.rain_nw = req_tdata[49:42];
   assign pix.rain_ne = req_tdata[57:50];
   assign pix.rain_sw = req_tdata[65:58];
   assign pix.rain_se = req_tdata[73:66];
   assign pix.frac_x = req_tdata[89:74];
   assign pix.frac_y = req_tdata[105:90];
   assign pix.interp_on = req_tuser[1];

   // A stage loads when it is empty or its contents move on in the same cycle.
   always_comb begin
      stage_rdy[NUM_STAGES] = rsp_tready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         stage_rdy[k] = !vld_ff[k] || stage_rdy[k+1];
      end
      ctrl.load = stage_rdy[NUM_STAGES-1:0];
      vld_in = vld_ff;
      if (stage_rdy[0]) begin
         vld_in[0] = req_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (stage_rdy[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = stage_rdy[0];
   assign rsp_tvalid = vld_ff[NUM_STAGES-1];
   assign rsp_tdata = {blue, green, red};

   tps_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .cfg(cfg)
   );

   tps_front u_front (
      .clock(clock),
      .ctrl(ctrl),
      .cfg(cfg),
      .pix(pix),
      .result(front)
   );

   tps_color u_color (
      .clock(clock),
      .ctrl(ctrl),
      .cfg(cfg),
      .front(front),
      .red(red),
      .green(green),
      .blue(blue)
   );

endmodule
